// File: design/pbrle_pkg.sv
// ----------------------------------------------------------------------------
// pbrle_pkg
// Shared types and constants of the PackBytes run-length decoder.
// ----------------------------------------------------------------------------
package pbrle_pkg;

  localparam int BYTE_W  = 8;
  localparam int COUNT_W = 7;
  localparam int FILL_W  = 3;
  localparam int VALID_W = 3;
  localparam int WORD_BYTES = 4;

  // Run types carried in bits 7..6 of a flag byte
  localparam logic [1:0] KIND_LITERAL = 2'd0;
  localparam logic [1:0] KIND_BYTE    = 2'd1;
  localparam logic [1:0] KIND_QUAD    = 2'd2;
  localparam logic [1:0] KIND_BYTE4   = 2'd3;

  localparam logic [5:0] COUNT_MASK = 6'h3f;

  // Commands from controller to datapath
  typedef struct packed {
    logic take_flag;
    logic take_lit;
    logic take_pat;
    logic emit;
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic out_free;
    logic flag_literal;
    logic lit_last;
    logic gather_done;
    logic emit_last;
  } status_t;

endpackage

// File: design/pbrle_ifs.sv
// ----------------------------------------------------------------------------
// pbrle channel interfaces
// Valid/ready channels for packed input bytes and decoded output words.
// ----------------------------------------------------------------------------
interface pbrle_stream_if;
  logic       valid;
  logic       ready;
  logic [7:0] stream_byte;

  modport source (output valid, output stream_byte, input ready);
  modport sink (input valid, input stream_byte, output ready);
endinterface

interface pbrle_word_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte_first;
  logic [7:0] out_byte_second;
  logic [7:0] out_byte_third;
  logic [7:0] out_byte_fourth;
  logic [2:0] valid_bytes;
  logic       run_end;

  modport source (output valid, output out_byte_first, output out_byte_second,
                  output out_byte_third, output out_byte_fourth,
                  output valid_bytes, output run_end, input ready);
  modport sink (input valid, input out_byte_first, input out_byte_second,
                input out_byte_third, input out_byte_fourth,
                input valid_bytes, input run_end, output ready);
endinterface

// File: design/pbrle_datapath.sv
// ----------------------------------------------------------------------------
// pbrle_datapath
// Run registers, pattern store and the output word register.
// ----------------------------------------------------------------------------
module pbrle_datapath (
  input  logic                                clk,
  input  logic                                rst,
  input  logic [pbrle_pkg::BYTE_W-1:0]        stream_byte,
  input  pbrle_pkg::cmd_t                     cmd,
  output pbrle_pkg::status_t                  status,
  input  logic                                word_ready,
  output logic                                word_valid,
  output logic [pbrle_pkg::BYTE_W-1:0]        word_bytes [pbrle_pkg::WORD_BYTES],
  output logic [pbrle_pkg::VALID_W-1:0]       word_count,
  output logic                                word_last
);

  logic [1:0]                         run_kind;
  logic [pbrle_pkg::COUNT_W-1:0]      run_count;
  logic [pbrle_pkg::FILL_W-1:0]       gathered;
  logic [pbrle_pkg::BYTE_W-1:0]       pattern_store [pbrle_pkg::WORD_BYTES];

  logic [pbrle_pkg::FILL_W-1:0]       fill_next;
  logic [pbrle_pkg::COUNT_W-1:0]      count_dec;
  logic                               lit_word;
  logic [pbrle_pkg::BYTE_W-1:0]       merged [pbrle_pkg::WORD_BYTES];
  logic [pbrle_pkg::BYTE_W-1:0]       load_bytes [pbrle_pkg::WORD_BYTES];
  logic [pbrle_pkg::VALID_W-1:0]      load_count;
  logic                               load_last;
  logic                               load;
  logic [pbrle_pkg::COUNT_W-1:0]      emit_step;

  assign fill_next = gathered + 3'd1;
  assign count_dec = run_count - 7'd1;

  assign status.out_free     = !word_valid || word_ready;
  assign status.flag_literal = (stream_byte[7:6] == pbrle_pkg::KIND_LITERAL);
  assign status.lit_last     = (run_count == 7'd1);
  assign status.gather_done  = (run_kind == pbrle_pkg::KIND_QUAD) ?
                               (gathered == 3'd3) : 1'b1;
  assign status.emit_last    = (run_kind == pbrle_pkg::KIND_BYTE) ?
                               (run_count <= 7'd4) : (run_count == 7'd1);

  assign lit_word = (fill_next == 3'd4) || (run_count == 7'd1);
  assign load     = (cmd.take_lit && lit_word) || cmd.emit;

  // Kind 1 consumes up to four bytes a word, the others one repetition a word
  assign emit_step = (run_kind == pbrle_pkg::KIND_BYTE) ?
                     ((run_count >= 7'd4) ? 7'd4 : run_count) : 7'd1;

  always_comb begin
    for (int i = 0; i < pbrle_pkg::WORD_BYTES; i++) begin
      merged[i] = (i == int'(gathered[1:0])) ? stream_byte : pattern_store[i];
    end
    if (cmd.take_lit) begin
      load_count = fill_next;
      load_last  = (run_count == 7'd1);
      for (int i = 0; i < pbrle_pkg::WORD_BYTES; i++) begin
        load_bytes[i] = (i < int'(fill_next)) ? merged[i] : '0;
      end
    end else if (run_kind == pbrle_pkg::KIND_BYTE) begin
      load_count = emit_step[pbrle_pkg::VALID_W-1:0];
      load_last  = status.emit_last;
      for (int i = 0; i < pbrle_pkg::WORD_BYTES; i++) begin
        load_bytes[i] = (i < int'(emit_step)) ? pattern_store[0] : '0;
      end
    end else begin
      load_count = 3'd4;
      load_last  = status.emit_last;
      for (int i = 0; i < pbrle_pkg::WORD_BYTES; i++) begin
        load_bytes[i] = (run_kind == pbrle_pkg::KIND_QUAD) ? pattern_store[i]
                                                           : pattern_store[0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run_kind   <= pbrle_pkg::KIND_LITERAL;
      run_count  <= '0;
      gathered   <= '0;
      word_valid <= 1'b0;
    end else begin
      if (load) begin
        word_valid <= 1'b1;
      end else if (word_ready) begin
        word_valid <= 1'b0;
      end

      if (cmd.take_flag) begin
        run_kind  <= stream_byte[7:6];
        run_count <= {1'b0, stream_byte[5:0] & pbrle_pkg::COUNT_MASK} + 7'd1;
        gathered  <= '0;
      end else if (cmd.take_lit) begin
        run_count <= count_dec;
        gathered  <= lit_word ? 3'd0 : fill_next;
      end else if (cmd.take_pat) begin
        gathered <= fill_next;
      end else if (cmd.emit) begin
        run_count <= run_count - emit_step;
        gathered  <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_lit || cmd.take_pat) begin
      pattern_store[gathered[1:0]] <= stream_byte;
    end
    if (load) begin
      word_bytes <= load_bytes;
      word_count <= load_count;
      word_last  <= load_last;
    end
  end

endmodule

// File: design/pbrle_controller.sv
// ----------------------------------------------------------------------------
// pbrle_controller
// Sequencer: flag, literal, pattern gathering and repeat expansion.
// ----------------------------------------------------------------------------
module pbrle_controller (
  input  logic                clk,
  input  logic                rst,
  input  logic                stream_valid,
  output logic                stream_ready,
  input  pbrle_pkg::status_t  status,
  output pbrle_pkg::cmd_t     cmd
);

  localparam logic [1:0] ST_FLAG   = 2'd0;
  localparam logic [1:0] ST_LIT    = 2'd1;
  localparam logic [1:0] ST_PAT    = 2'd2;
  localparam logic [1:0] ST_EXPAND = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       accept;

  // Hold input while expanding or while the output word cannot move
  assign stream_ready = status.out_free && (state != ST_EXPAND);
  assign accept       = stream_valid && stream_ready;

  assign cmd.take_flag = accept && (state == ST_FLAG);
  assign cmd.take_lit  = accept && (state == ST_LIT);
  assign cmd.take_pat  = accept && (state == ST_PAT);
  assign cmd.emit      = (state == ST_EXPAND) && status.out_free;

  always_comb begin
    state_next = state;
    case (state)
      ST_FLAG: begin
        if (accept) begin
          state_next = status.flag_literal ? ST_LIT : ST_PAT;
        end
      end
      ST_LIT: begin
        if (accept && status.lit_last) begin
          state_next = ST_FLAG;
        end
      end
      ST_PAT: begin
        if (accept && status.gather_done) begin
          state_next = ST_EXPAND;
        end
      end
      ST_EXPAND: begin
        if (cmd.emit && status.emit_last) begin
          state_next = ST_FLAG;
        end
      end
      default: begin
        state_next = ST_FLAG;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_FLAG;
    end else begin
      state <= state_next;
    end
  end

endmodule

// File: design/packbytes_run_length_decoder.sv
// ----------------------------------------------------------------------------
// packbytes_run_length_decoder
// PackBytes run-length decoder: packed bytes in, words of up to four bytes out.
// ----------------------------------------------------------------------------
// Usage:
//   stream carries one packed byte per request (flag or data); words carries
//   one decoded word per request, with valid_bytes (1 to 4) and run_end set
//   on the last word of each run. Bytes past valid_bytes read as zero.
//   A literal word leaves the output register the cycle after the byte that
//   fills it (four bytes, or the last byte of the run). After the last pattern
//   byte of a repeat run the expansion sends one word per cycle while the
//   receiver does not stall, up to 64 words, and the input is held meanwhile;
//   that rate is set by the single output word register.
//   When the receiver stalls, the output word holds and the input is held
//   until that word is taken, flag bytes included. Synchronous reset
//   returns the sequencer to awaiting a flag byte and drops any word held.
// ----------------------------------------------------------------------------
module packbytes_run_length_decoder (
  input  logic            clk,
  input  logic            rst,
  pbrle_stream_if.sink    stream,
  pbrle_word_if.source    words
);

  pbrle_pkg::cmd_t    cmd;
  pbrle_pkg::status_t status;
  logic [pbrle_pkg::BYTE_W-1:0] word_bytes [pbrle_pkg::WORD_BYTES];

  // Sequencer: decides which request each byte is and when to expand
  pbrle_controller u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .stream_valid (stream.valid),
    .stream_ready (stream.ready),
    .status       (status),
    .cmd          (cmd)
  );

  // Run registers, pattern store and output word register
  pbrle_datapath u_dp (
    .clk         (clk),
    .rst         (rst),
    .stream_byte (stream.stream_byte),
    .cmd         (cmd),
    .status      (status),
    .word_ready  (words.ready),
    .word_valid  (words.valid),
    .word_bytes  (word_bytes),
    .word_count  (words.valid_bytes),
    .word_last   (words.run_end)
  );

  assign words.out_byte_first  = word_bytes[0];
  assign words.out_byte_second = word_bytes[1];
  assign words.out_byte_third  = word_bytes[2];
  assign words.out_byte_fourth = word_bytes[3];

endmodule

// File: bench/tb_packbytes_run_length_decoder.sv
// ----------------------------------------------------------------------------
// tb_packbytes_run_length_decoder
// Self-checking bench for the PackBytes run-length decoder. Packed bytes go in
// on the stream channel with random gaps, and decoded words come back on the
// word channel under random back-pressure. A software copy of the decoder
// predicts every word, and each word is checked against it in order.
// ----------------------------------------------------------------------------
module tb_packbytes_run_length_decoder;
  timeunit 1ns;
  timeprecision 1ps;

  import pbrle_pkg::*;

  // Sequencer phases of the software decoder
  localparam logic [1:0] AWAIT_FLAG     = 2'd0;
  localparam logic [1:0] TAKE_LITERAL   = 2'd1;
  localparam logic [1:0] GATHER_PATTERN = 2'd2;

  localparam int RANDOM_BYTES = 230;
  localparam int IDLE_LIMIT   = 2000;  // cycles with no request on either side
  localparam int DRAIN_CYCLES = 16;

  typedef struct packed {
    logic [3:0][BYTE_W-1:0] bytes;  // bytes[0] is the first decoded byte
    logic [VALID_W-1:0]     valid_bytes;
    logic                   run_end;
  } word_t;

  // Tracks the decoder state and holds the words still owed by the block.
  class expansion_tracker;
    logic [1:0]             phase;
    logic [1:0]             kind;
    int                     remaining;
    int                     gathered;
    int                     mismatches;
    logic [3:0][BYTE_W-1:0] held;
    word_t                  due_words[$];

    function new();
      phase      = AWAIT_FLAG;
      kind       = KIND_LITERAL;
      remaining  = 0;
      gathered   = 0;
      mismatches = 0;
      held       = '0;
    endfunction

    task report(string msg);
      mismatches++;
      $display("[%0t] error: %s", $time, msg);
    endtask

    function void push_word(logic [3:0][BYTE_W-1:0] src, int valid, bit last);
      word_t w;
      w.bytes = '0;
      for (int i = 0; i < valid; i++)
        w.bytes[i] = src[i];
      w.valid_bytes = VALID_W'(valid);
      w.run_end     = last;
      due_words.push_back(w);
    endfunction

    function void note_byte(logic [BYTE_W-1:0] b);
      int                     need;
      int                     left;
      int                     v;
      logic [3:0][BYTE_W-1:0] pat;
      case (phase)
        TAKE_LITERAL: begin
          held[gathered] = b;
          gathered++;
          remaining--;
          if (gathered == WORD_BYTES || remaining == 0) begin
            push_word(held, gathered, remaining == 0);
            gathered = 0;
            if (remaining == 0)
              phase = AWAIT_FLAG;
          end
        end
        GATHER_PATTERN: begin
          held[gathered] = b;
          gathered++;
          need = (kind == KIND_QUAD) ? WORD_BYTES : 1;
          if (gathered >= need) begin
            if (kind == KIND_BYTE) begin
              pat  = {4{held[0]}};
              left = remaining;
              while (left > 0) begin
                v = (left >= WORD_BYTES) ? WORD_BYTES : left;
                left -= v;
                push_word(pat, v, left == 0);
              end
            end else begin
              pat = (kind == KIND_QUAD) ? held : {4{held[0]}};
              for (int r = 0; r < remaining; r++)
                push_word(pat, WORD_BYTES, r + 1 == remaining);
            end
            phase     = AWAIT_FLAG;
            gathered  = 0;
            remaining = 0;
          end
        end
        default: begin
          kind      = b[7:6];
          remaining = int'(b[5:0] & COUNT_MASK) + 1;
          gathered  = 0;
          phase     = (kind == KIND_LITERAL) ? TAKE_LITERAL : GATHER_PATTERN;
        end
      endcase
    endfunction

    task check_word(word_t got);
      word_t want;
      if (due_words.size() == 0) begin
        report($sformatf("word %h arrived with nothing outstanding", got));
        return;
      end
      want = due_words.pop_front();
      for (int i = 0; i < WORD_BYTES; i++)
        if (got.bytes[i] !== want.bytes[i])
          report($sformatf("byte lane %0d: got %h, want %h",
                           i, got.bytes[i], want.bytes[i]));
      if (got.valid_bytes !== want.valid_bytes)
        report($sformatf("valid_bytes: got %0d, want %0d",
                         got.valid_bytes, want.valid_bytes));
      if (got.run_end !== want.run_end)
        report($sformatf("run_end: got %b, want %b", got.run_end, want.run_end));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst;

  // When set, both sides run flat out so back-to-back requests get exercised
  bit steady = 1'b0;
  int bytes_sent = 0;
  int idle_cycles = 0;

  expansion_tracker tracker = new();

  pbrle_stream_if stream_ch ();
  pbrle_word_if   word_ch ();

  packbytes_run_length_decoder dut (
    .clk    (clk),
    .rst    (rst),
    .stream (stream_ch),
    .words  (word_ch)
  );

  always #6 clk = ~clk;

  // Offer one byte, hold it until the request is taken, then note it.
  // An optional gap with valid low comes first.
  task send_byte(logic [BYTE_W-1:0] b);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      stream_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    stream_ch.valid       <= 1'b1;
    stream_ch.stream_byte <= b;
    @(posedge clk);
    while (stream_ch.ready !== 1'b1) @(posedge clk);
    tracker.note_byte(b);
    bytes_sent++;
  endtask

  // One well-formed run: flag byte, then the data bytes that its type needs.
  task send_run(logic [1:0] kind, int count);
    int data_bytes;
    data_bytes = (kind == KIND_LITERAL) ? count :
                 (kind == KIND_QUAD)    ? WORD_BYTES : 1;
    send_byte({kind, 6'(count - 1)});
    repeat (data_bytes) send_byte(BYTE_W'($urandom_range(0, 255)));
  endtask

  // Mostly short runs to keep the expansion quick, with the full 64 now and then
  function automatic int pick_count();
    int roll;
    roll = $urandom_range(0, 9);
    if (roll == 0)
      return 64;
    if (roll == 1)
      return $urandom_range(1, 64);
    return $urandom_range(1, 8);
  endfunction

  // Receiver: draw a stall for every word, then hold ready until one is taken.
  initial begin : word_receiver
    int stall;
    word_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      stall = steady ? 0 : $urandom_range(0, 9);
      if (stall > 0) begin
        word_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      word_ch.ready <= 1'b1;
      @(posedge clk);
      while (word_ch.valid !== 1'b1) @(posedge clk);
    end
  end

  // Check each word at the edge that takes it.
  always @(posedge clk) begin
    if (!rst && word_ch.valid === 1'b1 && word_ch.ready === 1'b1)
      tracker.check_word('{bytes: {word_ch.out_byte_fourth, word_ch.out_byte_third,
                                   word_ch.out_byte_second, word_ch.out_byte_first},
                           valid_bytes: word_ch.valid_bytes,
                           run_end: word_ch.run_end});
  end

  // Watchdog: any request on either channel counts as progress.
  always @(posedge clk) begin
    if (rst || (stream_ch.valid === 1'b1 && stream_ch.ready === 1'b1) ||
        (word_ch.valid === 1'b1 && word_ch.ready === 1'b1)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles + 1 >= IDLE_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int target;
    // Opening sequence: repeat runs of every type at count 1 and 64, literal runs
    // of one byte and of a word plus one byte, and data bytes at both extremes.
    logic [BYTE_W-1:0] opening[] = '{
      {KIND_LITERAL, 6'd0},  8'h00,
      {KIND_LITERAL, 6'd4},  8'hff, 8'h01, 8'h80, 8'h7f, 8'h5a,
      {KIND_BYTE, 6'd0},     8'haa,
      {KIND_BYTE, 6'd63},    8'h55,
      {KIND_QUAD, 6'd0},     8'h00, 8'hff, 8'h12, 8'hed,
      {KIND_QUAD, 6'd63},    8'hc3, 8'h3c, 8'h81, 8'h7e,
      {KIND_BYTE4, 6'd0},    8'hff,
      {KIND_BYTE4, 6'd63},   8'h00
    };
    rst                   <= 1'b1;
    stream_ch.valid       <= 1'b0;
    stream_ch.stream_byte <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (opening[i]) send_byte(opening[i]);

    // Random part: mostly well-formed runs with random content. A stray byte
    // now and then knocks the stream out of step, so the following flag is
    // taken as data and a random byte becomes the next flag.
    target = bytes_sent + RANDOM_BYTES;
    while (bytes_sent < target) begin
      steady = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 9) == 0)
        send_byte(BYTE_W'($urandom_range(0, 255)));
      else
        send_run(2'($urandom_range(0, 3)), pick_count());
    end
    stream_ch.valid <= 1'b0;
    steady = 1'b0;

    // Drain: wait for every owed word, then give a trailing flag time to settle
    while (tracker.due_words.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (tracker.mismatches == 0 && tracker.due_words.size() == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule

// File: packbytes_run_length_decoder.f
design/pbrle_pkg.sv
design/pbrle_ifs.sv
design/pbrle_datapath.sv
design/pbrle_controller.sv
design/packbytes_run_length_decoder.sv
bench/tb_packbytes_run_length_decoder.sv
